@@ rtl/core/capture_frequency_meter_unit_assert.svh @@
// Assertion macros shared by the capture frequency meter RTL.
// Uses the including module's clk and rst; no other dependencies.
`ifndef CAPTURE_FREQUENCY_METER_UNIT_ASSERT_SVH
`define CAPTURE_FREQUENCY_METER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define CFMU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfmu assertion failed (same cycle)");
// Consequent must hold in the cycle after the antecedent
`define CFMU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfmu assertion failed (next cycle)");
`else
`define CFMU_ASSERT_SAME(lbl, ante, cons)
`define CFMU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/cfmu_pkg.sv @@
// Shared types, widths, register indexes and reset values for the
// capture frequency meter. No dependencies.
package cfmu_pkg;

  // Field and register widths
  localparam int TICK_W     = 27;
  localparam int FREQ_W     = 16;
  localparam int STALE_W    = 7;
  localparam int MASK_W     = 32;
  localparam int CH_W       = 5;
  localparam int CNT_IN_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W  = 24;  // channel + captured_count, padded to bytes
  localparam int M_TDATA_W  = 16;

  // Parameter defaults
  localparam int CHANNELS_DEF   = 32;
  localparam int COUNT_BITS_DEF = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd3;

  // Register reset values
  localparam logic [TICK_W-1:0]  TICK_RATE_RST   = 27'd1000000;
  localparam logic [FREQ_W-1:0]  MAX_FREQ_RST    = 16'd5000;
  localparam logic [STALE_W-1:0] STALE_LIMIT_RST = 7'd30;
  localparam logic [MASK_W-1:0]  ENABLE_MASK_RST = 32'd0;

  // Staleness saturates here
  localparam logic [STALE_W-1:0] STALE_SAT = 7'd100;

  // Item kinds
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Result status
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_DISABLED = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_DIV,
    S_WRITE,
    S_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch the input item
    logic fetch;      // read the channel entry
    logic div_start;  // start tick_rate / delta
    logic write;      // write the updated entry back
    logic load_out;   // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enabled;
    logic is_read;
    logic zero_delta;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/cfmu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/cfmu_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on the assertion macro header.
`include "capture_frequency_meter_unit_assert.svh"

module cfmu_div #(
  parameter int DIVIDEND_W = 27,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 qbit;

  // One trial subtraction per step
  always_comb begin
    shifted = {rem, quotient[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, divisor};
    qbit    = (shifted >= {1'b0, divisor});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= qbit ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], qbit};
    end
  end

  assign done = !busy;

  `CFMU_ASSERT_NEXT(a_start_busy, start, busy)
  `CFMU_ASSERT_NEXT(a_last_step, busy && !start && cnt == CNT_W'(DIVIDEND_W - 1), !busy)
  `CFMU_ASSERT_NEXT(a_idle_stays, !busy && !start, !busy)

endmodule

@@ rtl/core/cfmu_datapath.sv @@
// Datapath: configuration registers, item latch, channel state RAM,
// divider, update logic and output register. Depends on cfmu_pkg,
// cfmu_ram and cfmu_div.
module cfmu_datapath #(
  parameter int CHANNELS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cfmu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfmu_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [cfmu_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cfmu_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tuser,
  input  cfmu_pkg::cmd_t                    cmd,
  output cfmu_pkg::sts_t                    sts
);

  import cfmu_pkg::*;

  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W = STALE_W + FREQ_W + COUNT_BITS;

  // Configuration registers
  logic [TICK_W-1:0]  tick_rate;
  logic [FREQ_W-1:0]  max_frequency;
  logic [STALE_W-1:0] stale_limit;
  logic [MASK_W-1:0]  enable_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate     <= TICK_RATE_RST;
      max_frequency <= MAX_FREQ_RST;
      stale_limit   <= STALE_LIMIT_RST;
      enable_mask   <= ENABLE_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK_RATE:   tick_rate     <= cfg_data[TICK_W-1:0];
        REG_MAX_FREQ:    max_frequency <= cfg_data[FREQ_W-1:0];
        REG_STALE_LIMIT: stale_limit   <= cfg_data[STALE_W-1:0];
        REG_ENABLE_MASK: enable_mask   <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Item latch
  logic                  op;
  logic [CH_W-1:0]       ch;
  logic [COUNT_BITS-1:0] now;
  logic [AW-1:0]         addr;
  logic                  enabled;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op  <= s_tuser;
      ch  <= s_tdata[CH_W-1:0];
      now <= COUNT_BITS'(s_tdata[CH_W +: CNT_IN_W]);
    end
  end

  assign addr    = AW'(ch);
  assign enabled = (32'(ch) < CHANNELS) && enable_mask[ch];

  // Channel state; entries never written read as zero
  logic [CHANNELS-1:0]   valid;
  logic                  ent_valid;
  logic [ENTRY_W-1:0]    rdata;
  logic [ENTRY_W-1:0]    wdata;
  logic [ENTRY_W-1:0]    entry;
  logic [COUNT_BITS-1:0] last;
  logic [FREQ_W-1:0]     held;
  logic [STALE_W-1:0]    stale;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.write) begin
      valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      ent_valid <= valid[addr];
    end
  end

  cfmu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (addr),
    .wdata (wdata),
    .re    (cmd.fetch),
    .raddr (addr),
    .rdata (rdata)
  );

  assign entry = ent_valid ? rdata : '0;
  assign last  = entry[COUNT_BITS-1:0];
  assign held  = entry[COUNT_BITS +: FREQ_W];
  assign stale = entry[COUNT_BITS + FREQ_W +: STALE_W];

  // Tick delta wraps at the counter width
  logic [COUNT_BITS-1:0] delta;
  logic                  zero_delta;
  logic                  div_done;
  logic [TICK_W-1:0]     quotient;

  assign delta      = now - last;
  assign zero_delta = (delta == '0);

  cfmu_div #(
    .DIVIDEND_W (TICK_W),
    .DIVISOR_W  (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (tick_rate),
    .divisor  (delta),
    .done     (div_done),
    .quotient (quotient)
  );

  // Entry update
  logic               take_q;
  logic               stale_hit;
  logic [FREQ_W-1:0]  cap_held;
  logic [FREQ_W-1:0]  rd_held;
  logic [STALE_W-1:0] rd_stale;

  always_comb begin
    take_q    = !zero_delta && (quotient < TICK_W'(max_frequency));
    cap_held  = take_q ? quotient[FREQ_W-1:0] : held;
    stale_hit = (stale >= stale_limit);
    rd_held   = stale_hit ? '0 : held;
    rd_stale  = (stale < STALE_SAT) ? stale + 1'b1 : stale;
    if (op == OP_READ) begin
      wdata = {rd_stale, rd_held, last};
    end else begin
      wdata = {STALE_W'(0), cap_held, now};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= enabled ? rd_held : '0;
      m_tuser <= enabled ? ST_OK : ST_DISABLED;
    end
  end

  // Status to controller
  always_comb begin
    sts.enabled    = enabled;
    sts.is_read    = (op == OP_READ);
    sts.zero_delta = zero_delta;
    sts.div_done   = div_done;
    sts.out_free   = !m_tvalid || m_tready;
  end

endmodule

@@ rtl/core/cfmu_ctrl.sv @@
// Controller state machine sequencing fetch, divide, write-back and result.
// Depends on cfmu_pkg and the assertion macro header.
`include "capture_frequency_meter_unit_assert.svh"

module cfmu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  cfmu_pkg::sts_t sts,
  output cfmu_pkg::cmd_t cmd
);

  import cfmu_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_tready      = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (sts.enabled) begin
          state_next = S_EVAL;
        end else if (sts.is_read) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EVAL: begin
        if (!sts.is_read && !sts.zero_delta) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = sts.is_read ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `CFMU_ASSERT_NEXT(a_accept_fetch, cmd.accept, state == S_FETCH)
  `CFMU_ASSERT_NEXT(a_div_to_write, state == S_DIV && sts.div_done, state == S_WRITE)
  `CFMU_ASSERT_SAME(a_load_free, cmd.load_out, sts.out_free)

endmodule

@@ rtl/core/capture_frequency_meter_unit.sv @@
// Top level of the capture frequency meter: controller plus datapath.
// Depends on cfmu_pkg, cfmu_ctrl and cfmu_datapath.
//
// Per-channel frequency meter. Input items on s_* are either a timer capture
// (s_tuser = 0) or a read request (s_tuser = 1); a read returns one result
// item on m_* with the held frequency in hertz and a status flag, a capture
// returns nothing. One item is processed at a time. An enabled capture with a
// nonzero tick delta runs fetch, evaluate, divide and write-back before the next
// item is taken, the radix-2 divider giving one quotient bit per cycle over the
// 27-bit tick_rate. A zero-delta capture skips the divide, a disabled capture
// ends after fetch, a disabled read goes from fetch to result, an enabled read
// runs evaluate and write-back; results wait for the output register to free,
// then sit there while the next item is accepted. Channel state starts at zero
// after reset without a clearing pass. Configuration is to be written through
// cfg_we / cfg_index / cfg_data only while idle; the block does not enforce this.
module capture_frequency_meter_unit #(
  parameter int CHANNELS   = cfmu_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = cfmu_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [cfmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfmu_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cfmu_pkg::S_TDATA_W-1:0]  s_tdata,   // [4:0] channel, [20:5] captured_count
  input  logic                            s_tuser,   // [0] op
  // Result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cfmu_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] frequency
  output logic                            m_tuser    // [0] status
);

  import cfmu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cfmu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfmu_datapath #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
